// File: src/ssag_pkg.sv
// ----------------------------------------------------------------------------
// ssag_pkg
// Shared constants and types of the strided slice address generator.
// ----------------------------------------------------------------------------
package ssag_pkg;

    localparam int SLOT_BITS         = 16;
    localparam int DIMS_DEFAULT      = 4;
    localparam int SIZE_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_BITS    = 8;
    localparam int CFG_DATA_BITS     = 64;
    localparam int ADDR_BITS         = 32;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_SLICE_BEGINS  = cfg_index_t'(0);
    localparam cfg_index_t REG_SLICE_STRIDES = cfg_index_t'(1);
    localparam cfg_index_t REG_OUTPUT_SIZES  = cfg_index_t'(2);
    localparam cfg_index_t REG_INPUT_SIZES   = cfg_index_t'(3);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic coord_en;  // register coordinate and extent of the current step
        logic acc_en;    // fold the registered coordinate into the offset
        logic finish;    // load the result word, advance the counters
    } ssag_cmd_t;

endpackage

// File: src/ssag_ctrl.sv
// ----------------------------------------------------------------------------
// ssag_ctrl
// Sequencer: takes a request, walks the dimensions, hands off the result.
// ----------------------------------------------------------------------------
module ssag_ctrl
    import ssag_pkg::*;
#(
    parameter int DIMS       = DIMS_DEFAULT,
    parameter int STEP_BITS  = $clog2(DIMS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssag_cmd_t            cmd,
    output logic [STEP_BITS-1:0] step
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WAIT
    } state_t;

    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIMS);

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 can_load;

    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    step_next  = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.coord_en = (step_reg != LAST_STEP);
                cmd.acc_en   = (step_reg != '0);
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (can_load)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign step      = step_reg;

endmodule

// File: src/ssag_datapath.sv
// ----------------------------------------------------------------------------
// ssag_datapath
// Configuration registers, coordinate counters, offset accumulator, result.
// ----------------------------------------------------------------------------
module ssag_datapath
    import ssag_pkg::*;
#(
    parameter int DIMS      = DIMS_DEFAULT,
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT,
    parameter int STEP_BITS = $clog2(DIMS + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     restart,
    input  ssag_cmd_t                cmd,
    input  logic [STEP_BITS-1:0]     step,
    output logic [ADDR_BITS-1:0]     dest_index,
    output logic [ADDR_BITS-1:0]     source_offset,
    output logic                     last
);

    localparam int DIM_IDX_BITS = (DIMS > 1) ? $clog2(DIMS) : 1;

    logic [CFG_DATA_BITS-1:0] begins_reg, strides_reg, out_sizes_reg, in_sizes_reg;

    logic [SLOT_BITS-1:0] begin_slot [DIMS];
    logic [SLOT_BITS-1:0] stride_slot [DIMS];
    logic [SLOT_BITS-1:0] out_ext [DIMS];
    logic [SLOT_BITS-1:0] in_ext [DIMS];

    logic [SLOT_BITS-1:0] cnt_reg [DIMS];
    logic [SLOT_BITS-1:0] cnt_next [DIMS];
    logic [DIMS-1:0]      at_end;
    logic [DIMS:0]        carry;
    logic [ADDR_BITS-1:0] lin_reg;
    logic                 last_w;

    logic [ADDR_BITS-1:0] coord_reg, acc_reg, ext_reg;
    logic [ADDR_BITS-1:0] dest_reg, src_reg;
    logic                 last_reg;

    logic [DIM_IDX_BITS-1:0] dim;
    logic [ADDR_BITS-1:0]    stride_w, coord_w;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begins_reg    <= '0;
            strides_reg   <= '0;
            out_sizes_reg <= '0;
            in_sizes_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SLICE_BEGINS:  begins_reg    <= cfg_data;
                REG_SLICE_STRIDES: strides_reg   <= cfg_data;
                REG_OUTPUT_SIZES:  out_sizes_reg <= cfg_data;
                REG_INPUT_SIZES:   in_sizes_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        for (int d = 0; d < DIMS; d++)
        begin
            begin_slot[d]  = begins_reg[SLOT_BITS*d +: SLOT_BITS];
            stride_slot[d] = strides_reg[SLOT_BITS*d +: SLOT_BITS];
            out_ext[d]     = SLOT_BITS'(out_sizes_reg[SLOT_BITS*d +: SIZE_BITS]);
            in_ext[d]      = SLOT_BITS'(in_sizes_reg[SLOT_BITS*d +: SIZE_BITS]);
            at_end[d]      = ({1'b0, cnt_reg[d]} + 1'b1) >= {1'b0, out_ext[d]};
        end
    end

    // Carry ripples from the innermost dimension outward
    always_comb
    begin
        carry[DIMS] = 1'b1;
        for (int d = DIMS - 1; d >= 0; d--)
        begin
            carry[d] = carry[d+1] && at_end[d];
        end
        last_w = carry[0];
        for (int d = 0; d < DIMS; d++)
        begin
            if (!carry[d+1])
            begin
                cnt_next[d] = cnt_reg[d];
            end
            else if (at_end[d])
            begin
                cnt_next[d] = '0;
            end
            else
            begin
                cnt_next[d] = cnt_reg[d] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                cnt_reg[d] <= '0;
            end
            lin_reg <= '0;
        end
        else if (cmd.accept && restart)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                cnt_reg[d] <= '0;
            end
            lin_reg <= '0;
        end
        else if (cmd.finish)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                cnt_reg[d] <= cnt_next[d];
            end
            lin_reg <= last_w ? '0 : lin_reg + 1'b1;
        end
    end

    // One dimension per step: coordinate, then fold into the offset
    assign dim      = step[DIM_IDX_BITS-1:0];
    assign stride_w = ADDR_BITS'(signed'(stride_slot[dim]));
    assign coord_w  = ADDR_BITS'(ADDR_BITS'(cnt_reg[dim]) * stride_w)
                    + ADDR_BITS'(begin_slot[dim]);

    always_ff @(posedge clk)
    begin
        if (cmd.coord_en)
        begin
            coord_reg <= coord_w;
            ext_reg   <= ADDR_BITS'(in_ext[dim]);
        end
        if (cmd.accept)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= ADDR_BITS'(acc_reg * ext_reg) + coord_reg;
        end
        if (cmd.finish)
        begin
            dest_reg <= lin_reg;
            src_reg  <= acc_reg;
            last_reg <= last_w;
        end
    end

    assign dest_index    = dest_reg;
    assign source_offset = src_reg;
    assign last          = last_reg;

endmodule

// File: src/strided_slice_address_generator.sv
// ----------------------------------------------------------------------------
// strided_slice_address_generator
// Gather-address generator for a strided tensor slice of up to DIMS dims.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | restart
//   out     | out       | out_valid/out_ready  | dest_index, source_offset, last
//
// Each request word is accepted, walked through the shared coordinate
// multiplier and offset multiply-add (one dimension per cycle, each
// coordinate registered before the accumulate folds it in) and loaded into
// the output register before the next one is accepted. A request may be
// accepted while the previous result word still waits in the output
// register; the block holds in the load cycle until that word is taken.
// Reset clears the configuration registers, counters and valid flag;
// configuration writes are taken every cycle.
//
module strided_slice_address_generator
    import ssag_pkg::*;
#(
    parameter int DIMS      = DIMS_DEFAULT,
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     restart,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ADDR_BITS-1:0]     dest_index,
    output logic [ADDR_BITS-1:0]     source_offset,
    output logic                     last
);

    localparam int STEP_BITS = $clog2(DIMS + 1);

    ssag_cmd_t            cmd;
    logic [STEP_BITS-1:0] step;

    // Configuration never stalls
    assign cfg_ready = 1'b1;

    // Sequence the dimension walk and own the result valid flag
    ssag_ctrl #(
        .DIMS      (DIMS),
        .STEP_BITS (STEP_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .step      (step)
    );

    // Hold configuration and counters, compute the offset, register the result
    ssag_datapath #(
        .DIMS      (DIMS),
        .SIZE_BITS (SIZE_BITS),
        .STEP_BITS (STEP_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .restart       (restart),
        .cmd           (cmd),
        .step          (step),
        .dest_index    (dest_index),
        .source_offset (source_offset),
        .last          (last)
    );

endmodule

// File: sim/ssag_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// ssag_scoreboard_pkg
// Address predictor and result check for the strided slice address generator.
// ----------------------------------------------------------------------------
package ssag_scoreboard_pkg;

    import ssag_pkg::*;

    localparam logic [SLOT_BITS-1:0] EXTENT_MASK =
        SLOT_BITS'((64'd1 << SIZE_BITS_DEFAULT) - 64'd1);

    typedef struct {
        logic [ADDR_BITS-1:0] dest;
        logic [ADDR_BITS-1:0] src;
        logic                 is_last;
    } gather_addr_t;

    class gather_addr_scoreboard;

        logic [CFG_DATA_BITS-1:0] begins;
        logic [CFG_DATA_BITS-1:0] strides;
        logic [CFG_DATA_BITS-1:0] out_sizes;
        logic [CFG_DATA_BITS-1:0] in_sizes;
        logic [SLOT_BITS-1:0]     coord [DIMS_DEFAULT];
        logic [ADDR_BITS-1:0]     elem_count;
        gather_addr_t             pending_addrs [$];
        int                       errors;

        function new();
            begins    = '0;
            strides   = '0;
            out_sizes = '0;
            in_sizes  = '0;
            errors    = 0;
            clear_counters();
        endfunction

        function void clear_counters();
            foreach (coord[d])
                coord[d] = '0;
            elem_count = '0;
        endfunction

        function logic [SLOT_BITS-1:0] slot(logic [CFG_DATA_BITS-1:0] r, int d);
            return r[SLOT_BITS*d +: SLOT_BITS];
        endfunction

        function logic [SLOT_BITS-1:0] extent(logic [CFG_DATA_BITS-1:0] r, int d);
            return slot(r, d) & EXTENT_MASK;
        endfunction

        // a dimension is done when its counter sits at or past its last value
        function bit dim_done(int d);
            return ({1'b0, coord[d]} + 1'b1) >= {1'b0, extent(out_sizes, d)};
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] v);
            case (idx)
                REG_SLICE_BEGINS:  begins    = v;
                REG_SLICE_STRIDES: strides   = v;
                REG_OUTPUT_SIZES:  out_sizes = v;
                REG_INPUT_SIZES:   in_sizes  = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_addrs.size();
        endfunction

        // work out the address word that an accepted request produces
        function void note_request(logic restart);
            gather_addr_t         w;
            logic [SLOT_BITS-1:0] st;
            logic [ADDR_BITS-1:0] stride;
            logic [ADDR_BITS-1:0] src_coord;
            logic [ADDR_BITS-1:0] acc;
            bit                   final_elem;

            if (restart)
                clear_counters();
            acc        = '0;
            final_elem = 1'b1;
            for (int d = 0; d < DIMS_DEFAULT; d++) begin
                st        = slot(strides, d);
                stride    = {{(ADDR_BITS-SLOT_BITS){st[SLOT_BITS-1]}}, st};
                src_coord = ADDR_BITS'(coord[d]) * stride + ADDR_BITS'(slot(begins, d));
                if (d == 0)
                    acc = src_coord;
                else
                    acc = acc * ADDR_BITS'(extent(in_sizes, d)) + src_coord;
                if (!dim_done(d))
                    final_elem = 1'b0;
            end
            w.dest    = elem_count;
            w.src     = acc;
            w.is_last = final_elem;
            pending_addrs.push_back(w);

            if (final_elem) begin
                clear_counters();
            end
            else begin
                for (int d = DIMS_DEFAULT - 1; d >= 0; d--) begin
                    if (dim_done(d)) begin
                        coord[d] = '0;
                    end
                    else begin
                        coord[d] = coord[d] + 1'b1;
                        break;
                    end
                end
                elem_count = elem_count + 1'b1;
            end
        endfunction

        // compare a received word with the oldest prediction
        function void check_word(logic [ADDR_BITS-1:0] dest, logic [ADDR_BITS-1:0] src,
                                 logic lst);
            gather_addr_t w;

            if (pending_addrs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: dest=%h src=%h last=%b", dest, src, lst);
                return;
            end
            w = pending_addrs.pop_front();
            if (dest !== w.dest || src !== w.src || lst !== w.is_last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected dest=%h src=%h last=%b, got dest=%h src=%h last=%b",
                             w.dest, w.src, w.is_last, dest, src, lst);
            end
        endfunction

    endclass

endpackage

// File: sim/tb_strided_slice_address_generator.sv
// ----------------------------------------------------------------------------
// tb_strided_slice_address_generator
// Drives request words through the slice address generator under a range of
// register settings and random backpressure, and checks every address word
// against an in-bench predictor of the counters and the offset arithmetic.
// ----------------------------------------------------------------------------
module tb_strided_slice_address_generator
    import ssag_pkg::*;
    import ssag_scoreboard_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 400;  // rough size of the random part
    localparam int HOLD_AT      = 150;  // result count that arms the long hold
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_MIN_LEFT = 4;   // words still to come in the phase

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     restart;
    logic                     out_valid;
    logic                     out_ready;
    logic [ADDR_BITS-1:0]     dest_index;
    logic [ADDR_BITS-1:0]     source_offset;
    logic                     last;

    gather_addr_scoreboard sb = new();

    int words_taken;
    int hold_left;
    int stall_left;
    int eager_left;
    bit held_once;
    int phase_left;

    strided_slice_address_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dest_index    (dest_index),
        .source_offset (source_offset),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run: ~470 words, each paying the
    // longest sender gap, the block's own processing and the longest receiver
    // stall, plus the long hold and the register phases.
    initial
    begin
        #5_000_000;
        $display("tb_strided_slice_address_generator: errors");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Result side: sample the handshake at the edge, check the word, then
    // pick out_ready for the next cycle. The long hold is counted here so
    // that the request side keeps offering words and the block backs up
    // into in_ready.
    // ------------------------------------------------------------------
    initial
    begin
        out_ready   <= 1'b0;
        words_taken = 0;
        hold_left   = 0;
        stall_left  = 0;
        eager_left  = 0;
        held_once   = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                sb.check_word(dest_index, source_offset, last);
                words_taken++;
            end
            // start the hold only while the sender still has words to offer
            if (!held_once && words_taken >= HOLD_AT && phase_left >= HOLD_MIN_LEFT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (eager_left > 0) begin
                // stretch with no backpressure at all
                out_ready <= 1'b1;
                eager_left--;
            end
            else if ($urandom_range(0, 99) < 25) begin
                out_ready  <= 1'b0;
                stall_left = pick_gap(1'b0);
            end
            else if ($urandom_range(0, 99) < 3) begin
                out_ready  <= 1'b1;
                eager_left = $urandom_range(40, 150);
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one request word; keep valid high from the previous word when
    // there is no gap so valid is never dropped and raised in one step.
    task automatic send_word(input logic rs, input bit burst);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(rs);
    endtask

    // Hold the request side idle until every predicted word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, v);
    endtask

    // Write all four registers, then one index past the map, which the block
    // must ignore.
    task automatic configure(input logic [CFG_DATA_BITS-1:0] b, input logic [CFG_DATA_BITS-1:0] s,
                             input logic [CFG_DATA_BITS-1:0] o, input logic [CFG_DATA_BITS-1:0] i);
        write_reg(REG_SLICE_BEGINS, b);
        write_reg(REG_SLICE_STRIDES, s);
        write_reg(REG_OUTPUT_SIZES, o);
        write_reg(REG_INPUT_SIZES, i);
        write_reg(cfg_index_t'(REG_INPUT_SIZES + 1 + $urandom_range(0, 251)),
                  {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Random setting: small output extents so the last element comes around
    // often, a mix of small and full-range begins, strides and input extents,
    // and now and then a register pinned at an extreme.
    task automatic random_setting();
        logic [CFG_DATA_BITS-1:0] b, s, o, i;
        int                       pick;
        for (int d = 0; d < DIMS_DEFAULT; d++) begin
            b[SLOT_BITS*d +: SLOT_BITS] = ($urandom_range(0, 1) == 0) ?
                SLOT_BITS'($urandom_range(0, 7)) : SLOT_BITS'($urandom);
            s[SLOT_BITS*d +: SLOT_BITS] = ($urandom_range(0, 1) == 0) ?
                SLOT_BITS'($urandom_range(0, 5)) - SLOT_BITS'(2) : SLOT_BITS'($urandom);
            o[SLOT_BITS*d +: SLOT_BITS] = ($urandom_range(0, 24) == 0) ?
                SLOT_BITS'($urandom) : SLOT_BITS'($urandom_range(0, 4));
            i[SLOT_BITS*d +: SLOT_BITS] = ($urandom_range(0, 1) == 0) ?
                SLOT_BITS'($urandom_range(0, 9)) : SLOT_BITS'($urandom);
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0: b = '1;
            1: s = {DIMS_DEFAULT{16'h8000}};
            2: s = {DIMS_DEFAULT{16'h7FFF}};
            3: i = '1;
            4: begin
                b = '0;
                i = '0;
            end
            default: ;
        endcase
        configure(b, s, o, i);
    endtask

    // ------------------------------------------------------------------
    // Request side and sequencing.
    // ------------------------------------------------------------------
    initial
    begin
        int  words_sent;
        int  phase_words;
        bit  burst;

        phase_left = 0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: every extent is zero, so each word is the last one
        // and the counters never move.
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b1);

        // Zero extent on one dimension, extreme strides and begins, restart
        // in the middle of the walk, and enough words to wrap past last.
        drain();
        configure({16'hFFFF, 16'h0000, 16'h0001, 16'h8000},
                  {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF},
                  {16'd2,    16'd3,    16'd0,    16'd1},
                  {16'hFFFF, 16'd5,    16'd0,    16'hFFFF});
        for (int k = 0; k < 10; k++)
            send_word(k == 2, 1'b0);

        // Full-range extents: advance the inner counter well past what the
        // next setting allows.
        drain();
        configure('1, {DIMS_DEFAULT{16'h7FFF}}, '1, '1);
        for (int k = 0; k < 5; k++)
            send_word(1'b0, 1'b1);

        // Shrink the extents without a restart; the inner counter now sits
        // beyond its extent and must carry out on the next step.
        drain();
        configure('0, {DIMS_DEFAULT{16'h0001}},
                  {16'd3, 16'd2, 16'd2, 16'd2}, {16'd4, 16'd3, 16'd2, 16'd7});
        for (int k = 0; k < 5; k++)
            send_word(1'b0, 1'b0);

        // Random phases: new setting per phase, restart now and then, and
        // some phases with no gaps on the request side.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            drain();
            random_setting();
            phase_words = $urandom_range(10, 50);
            burst       = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_words; k++) begin
                phase_left = phase_words - k;
                send_word($urandom_range(0, 11) == 0, burst);
                words_sent++;
            end
            phase_left = 0;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_strided_slice_address_generator: clean");
        else
            $display("tb_strided_slice_address_generator: errors");
        $finish;
    end

endmodule

// File: filelist.f
src/ssag_pkg.sv
src/ssag_ctrl.sv
src/ssag_datapath.sv
src/strided_slice_address_generator.sv
sim/ssag_scoreboard_pkg.sv
sim/tb_strided_slice_address_generator.sv
